// ===== src/sacl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared constants for the set-associative cache lookup block: address
// split, field widths and the default associativity.
// ----------------------------------------------------------------------------
package sacl_pkg;

  localparam int ADDR_BITS     = 64;
  localparam int LINE_BYTES    = 64;
  localparam int NUM_SETS      = 1024;
  localparam int NUM_WAYS_DEF  = 16;

  localparam int OFFSET_BITS   = $clog2(LINE_BYTES);
  localparam int SET_BITS      = $clog2(NUM_SETS);
  localparam int TAG_BITS      = ADDR_BITS - OFFSET_BITS - SET_BITS;

  // Widths of the reported way and set fields.
  localparam int WAY_OUT_BITS  = 4;
  localparam int SET_OUT_BITS  = 10;
  localparam int COUNT_BITS    = 32;

endpackage

`default_nettype wire

// ===== src/sacl_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/sacl_way_select.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_way_select
// Tag compare, hit/victim way choice and the updated tag, valid and recency
// rows for one set.
// ----------------------------------------------------------------------------
module sacl_way_select #(
  parameter int NUM_WAYS = 16,
  parameter int WAY_BITS = 4
) (
  input  wire logic [sacl_pkg::TAG_BITS-1:0]          tag,
  input  wire logic [NUM_WAYS*sacl_pkg::TAG_BITS-1:0] row_tags,
  input  wire logic [NUM_WAYS-1:0]                    row_valid,
  input  wire logic [NUM_WAYS*WAY_BITS-1:0]           row_order,
  output logic                                        hit,
  output logic      [WAY_BITS-1:0]                    way,
  output logic      [NUM_WAYS*sacl_pkg::TAG_BITS-1:0] new_tags,
  output logic      [NUM_WAYS-1:0]                    new_valid,
  output logic      [NUM_WAYS*WAY_BITS-1:0]           new_order
);
  import sacl_pkg::*;

  logic [NUM_WAYS-1:0] match;
  logic [WAY_BITS-1:0] hit_way;
  logic [WAY_BITS-1:0] victim;

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      match[w] = row_valid[w] && (row_tags[w*TAG_BITS +: TAG_BITS] == tag);
    end
    hit = |match;
    // Lowest matching way wins.
    hit_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_BITS'(w);
      end
    end
    // The least recent entry sits at the end of the order list.
    victim = row_order[(NUM_WAYS-1)*WAY_BITS +: WAY_BITS];
    way    = hit ? hit_way : victim;
  end

  // Move the chosen way to the front: every entry ahead of its old
  // position shifts one place toward the least recent end.
  always_comb begin
    logic seen;
    seen = 1'b0;
    new_order[WAY_BITS-1:0] = way;
    for (int i = 1; i < NUM_WAYS; i++) begin
      seen = seen | (row_order[(i-1)*WAY_BITS +: WAY_BITS] == way);
      new_order[i*WAY_BITS +: WAY_BITS] = seen ? row_order[i*WAY_BITS +: WAY_BITS]
                                               : row_order[(i-1)*WAY_BITS +: WAY_BITS];
    end
  end

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      new_tags[w*TAG_BITS +: TAG_BITS] = (!hit && (way == WAY_BITS'(w)))
                                         ? tag : row_tags[w*TAG_BITS +: TAG_BITS];
      new_valid[w] = row_valid[w] | (way == WAY_BITS'(w));
    end
  end

endmodule

`default_nettype wire

// ===== src/set_assoc_cache_lru_lookup.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup
// Set-associative cache directory with true LRU replacement.
// ----------------------------------------------------------------------------
// Each transfer on the input carries a byte address; the block looks up its
// set, reports hit or miss with the way and set, fills the least recently used
// way on a miss, and returns the running hit and miss totals. After reset the
// block runs a clearing pass over all NUM_SETS sets (1024 by default) that
// empties every set and restores the default recency order; no input is
// taken during that pass. A lookup first reads the set's tag and recency
// rows from the two memories, then compares, updates and writes them back.
// The next address is accepted while a finished result still waits in
// the output register; a result that cannot leave holds the write-back.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_lookup #(
  parameter int NUM_WAYS = sacl_pkg::NUM_WAYS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [sacl_pkg::ADDR_BITS-1:0]    address,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   hit,
  output logic      [sacl_pkg::WAY_OUT_BITS-1:0] way_used,
  output logic      [sacl_pkg::SET_OUT_BITS-1:0] set_used,
  output logic      [sacl_pkg::COUNT_BITS-1:0]   hit_total,
  output logic      [sacl_pkg::COUNT_BITS-1:0]   miss_total
);
  import sacl_pkg::*;

  localparam int WAY_BITS = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int TAG_W    = NUM_WAYS * TAG_BITS;
  localparam int ORDER_W  = NUM_WAYS * WAY_BITS;
  localparam int META_W   = NUM_WAYS + ORDER_W;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  state_t                  state;
  logic [SET_BITS-1:0]     clr_idx;
  logic [SET_BITS-1:0]     cur_set;
  logic [TAG_BITS-1:0]     cur_tag;
  logic [COUNT_BITS-1:0]   hit_count;
  logic [COUNT_BITS-1:0]   miss_count;

  logic                    in_accept;
  logic                    commit;
  logic [SET_BITS-1:0]     in_set;
  logic [ORDER_W-1:0]      init_order;

  logic [TAG_W-1:0]        tag_rd;
  logic [META_W-1:0]       meta_rd;
  logic                    meta_we;
  logic [SET_BITS-1:0]     meta_waddr;
  logic [META_W-1:0]       meta_wdata;

  logic                    lk_hit;
  logic [WAY_BITS-1:0]     lk_way;
  logic [TAG_W-1:0]        lk_tags;
  logic [NUM_WAYS-1:0]     lk_valid;
  logic [ORDER_W-1:0]      lk_order;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign in_set    = address[OFFSET_BITS +: SET_BITS];
  // The write-back happens only once the output register can take the result.
  assign commit    = (state == ST_LOOKUP) && (!out_valid || !out_stall);

  always_comb begin
    for (int i = 0; i < NUM_WAYS; i++) begin
      init_order[i*WAY_BITS +: WAY_BITS] = WAY_BITS'(i);
    end
  end

  assign meta_we    = (state == ST_CLEAR) || commit;
  assign meta_waddr = (state == ST_CLEAR) ? clr_idx : cur_set;
  assign meta_wdata = (state == ST_CLEAR) ? {{NUM_WAYS{1'b0}}, init_order}
                                          : {lk_valid, lk_order};

  sacl_ram #(
    .WIDTH (TAG_W),
    .DEPTH (NUM_SETS)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (commit),
    .wr_addr (cur_set),
    .wr_data (lk_tags),
    .rd_en   (in_accept),
    .rd_addr (in_set),
    .rd_data (tag_rd)
  );

  sacl_ram #(
    .WIDTH (META_W),
    .DEPTH (NUM_SETS)
  ) u_meta_ram (
    .clk     (clk),
    .wr_en   (meta_we),
    .wr_addr (meta_waddr),
    .wr_data (meta_wdata),
    .rd_en   (in_accept),
    .rd_addr (in_set),
    .rd_data (meta_rd)
  );

  sacl_way_select #(
    .NUM_WAYS (NUM_WAYS),
    .WAY_BITS (WAY_BITS)
  ) u_way_select (
    .tag       (cur_tag),
    .row_tags  (tag_rd),
    .row_valid (meta_rd[ORDER_W +: NUM_WAYS]),
    .row_order (meta_rd[ORDER_W-1:0]),
    .hit       (lk_hit),
    .way       (lk_way),
    .new_tags  (lk_tags),
    .new_valid (lk_valid),
    .new_order (lk_order)
  );

  assign hit_total  = hit_count;
  assign miss_total = miss_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_idx    <= '0;
      out_valid  <= 1'b0;
      hit_count  <= '0;
      miss_count <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + SET_BITS'(1);
          if (clr_idx == SET_BITS'(NUM_SETS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            cur_set <= in_set;
            cur_tag <= address[OFFSET_BITS + SET_BITS +: TAG_BITS];
            state   <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (commit) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (commit) begin
        out_valid <= 1'b1;
        hit       <= lk_hit;
        way_used  <= WAY_OUT_BITS'(lk_way);
        set_used  <= SET_OUT_BITS'(cur_set);
        if (lk_hit) begin
          hit_count <= hit_count + COUNT_BITS'(1);
        end else begin
          miss_count <= miss_count + COUNT_BITS'(1);
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/set_assoc_cache_lru_lookup_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup_tb
// Self-checking bench for the 16-way LRU cache directory. A directed table
// covers empty ways, full sets, eviction order and address extremes. Random
// accesses drawn from small pools of sets and tags follow. Typed table rows
// are checked against their table values, all others against a behavioral
// copy of the directory, with random back pressure on both channels.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_lookup_tb;
  import sacl_pkg::*;

  localparam int WAYS          = NUM_WAYS_DEF;
  localparam int MAX_IDLE      = 13;
  localparam int LONG_HOLD     = 400;
  localparam int RANDOM_ITEMS  = 750;
  localparam int DRAIN_CYCLES  = 32;
  localparam int CYCLE_LIMIT   = 200000;

  typedef struct packed {
    logic                    is_hit;
    logic [WAY_OUT_BITS-1:0] way;
    logic [SET_OUT_BITS-1:0] set_index;
    logic [COUNT_BITS-1:0]   hits;
    logic [COUNT_BITS-1:0]   misses;
  } lookup_result_t;

  typedef struct {
    logic [ADDR_BITS-1:0] addr;
    bit                   typed;
    lookup_result_t       want;
  } access_row_t;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [ADDR_BITS-1:0]    address = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    hit;
  logic [WAY_OUT_BITS-1:0] way_used;
  logic [SET_OUT_BITS-1:0] set_used;
  logic [COUNT_BITS-1:0]   hit_total;
  logic [COUNT_BITS-1:0]   miss_total;

  // Behavioral copy of the directory.
  logic [TAG_BITS-1:0]     line_tag [NUM_SETS][WAYS];
  logic [WAYS-1:0]         line_valid [NUM_SETS];
  logic [WAY_OUT_BITS-1:0] recency [NUM_SETS][WAYS];
  logic [COUNT_BITS-1:0]   hit_count;
  logic [COUNT_BITS-1:0]   miss_count;

  lookup_result_t pending_lookups[$];
  access_row_t    access_table[$];
  int             mismatches = 0;
  int             cycle_count = 0;
  bit             send_burst = 1'b0;
  bit             recv_burst = 1'b0;
  bit             hold_off_req = 1'b0;

  set_assoc_cache_lru_lookup dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .address    (address),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hit        (hit),
    .way_used   (way_used),
    .set_used   (set_used),
    .hit_total  (hit_total),
    .miss_total (miss_total)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic clear_directory();
    for (int s = 0; s < NUM_SETS; s++) begin
      line_valid[s] = '0;
      for (int w = 0; w < WAYS; w++) begin
        line_tag[s][w] = '0;
        recency[s][w]  = WAY_OUT_BITS'(w);
      end
    end
    hit_count  = '0;
    miss_count = '0;
  endtask

  // Looks up one access, updates the directory and returns the transfer
  // that the block should produce for it.
  function automatic lookup_result_t predict_lookup(input logic [ADDR_BITS-1:0] addr);
    logic [SET_BITS-1:0]     s;
    logic [TAG_BITS-1:0]     tag;
    logic [WAY_OUT_BITS-1:0] way;
    logic                    found;
    int                      pos;
    lookup_result_t          res;
    s     = addr[OFFSET_BITS +: SET_BITS];
    tag   = addr[ADDR_BITS-1 -: TAG_BITS];
    found = 1'b0;
    way   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!found && line_valid[s][w] && line_tag[s][w] == tag) begin
        found = 1'b1;
        way   = WAY_OUT_BITS'(w);
      end
    end
    if (found) begin
      hit_count++;
    end else begin
      miss_count++;
      way = recency[s][WAYS-1];
      line_tag[s][way]   = tag;
      line_valid[s][way] = 1'b1;
    end
    pos = WAYS - 1;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (recency[s][i] == way) pos = i;
    end
    for (int j = pos; j > 0; j--) recency[s][j] = recency[s][j-1];
    recency[s][0] = way;
    res.is_hit    = found;
    res.way       = way;
    res.set_index = s;
    res.hits      = hit_count;
    res.misses    = miss_count;
    return res;
  endfunction

  task automatic add_row(input logic [ADDR_BITS-1:0] addr, input bit typed,
                         input logic is_hit, input int way, input int set_index,
                         input int hits, input int misses);
    access_row_t row;
    row.addr           = addr;
    row.typed          = typed;
    row.want.is_hit    = is_hit;
    row.want.way       = WAY_OUT_BITS'(way);
    row.want.set_index = SET_OUT_BITS'(set_index);
    row.want.hits      = COUNT_BITS'(hits);
    row.want.misses    = COUNT_BITS'(misses);
    access_table = {access_table, row};
  endtask

  // Offers one address after a random idle gap and records the expected
  // transfer once the address has been taken.
  task automatic offer_access(input logic [ADDR_BITS-1:0] addr, input bit typed,
                              input lookup_result_t typed_want);
    lookup_result_t predicted;
    int             gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    address  <= addr;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted = predict_lookup(addr);
    if (typed) predicted = typed_want;
    pending_lookups = {pending_lookups, predicted};
  endtask

  // Result side: random stalls, one long hold on request, field checks.
  initial begin
    int             stall_cycles;
    int             result_index;
    lookup_result_t want;
    result_index = 0;
    wait (rst === 1'b0);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      stall_cycles = recv_burst ? 0 : $urandom_range(0, MAX_IDLE);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_cycles = LONG_HOLD;
      end
      if (stall_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      if (pending_lookups.size() == 0) begin
        report_mismatch($sformatf("transfer %0d arrived with no lookup outstanding",
                                  result_index));
      end else begin
        want = pending_lookups.pop_front();
        if (hit !== want.is_hit)
          report_mismatch($sformatf("transfer %0d hit %b, expected %b",
                                    result_index, hit, want.is_hit));
        if (way_used !== want.way)
          report_mismatch($sformatf("transfer %0d way_used %0d, expected %0d",
                                    result_index, way_used, want.way));
        if (set_used !== want.set_index)
          report_mismatch($sformatf("transfer %0d set_used %0d, expected %0d",
                                    result_index, set_used, want.set_index));
        if (hit_total !== want.hits)
          report_mismatch($sformatf("transfer %0d hit_total %0d, expected %0d",
                                    result_index, hit_total, want.hits));
        if (miss_total !== want.misses)
          report_mismatch($sformatf("transfer %0d miss_total %0d, expected %0d",
                                    result_index, miss_total, want.misses));
      end
      result_index++;
    end
  end

  initial begin
    logic [SET_BITS-1:0]    set_pool [8];
    logic [TAG_BITS-1:0]    tag_pool [20];
    logic [SET_BITS-1:0]    set_index;
    logic [TAG_BITS-1:0]    tag;
    logic [OFFSET_BITS-1:0] offset;
    logic [ADDR_BITS-1:0]   addr;
    int                     pick;

    clear_directory();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Block 0 must miss in an empty set, then hit, even though its tag is zero.
    add_row(64'h0, 1'b1, 1'b0, 15, 0, 0, 1);
    add_row(64'h3F, 1'b1, 1'b1, 15, 0, 1, 1);
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 15, 1023, 1, 2);
    add_row(64'hFFFF_FFFF_FFFF_FFC0, 1'b1, 1'b1, 15, 1023, 2, 2);
    // Fill the rest of set 0; empty ways go from the top down.
    for (int k = 1; k < WAYS; k++)
      add_row(64'(k) << 16, 1'b1, 1'b0, 15 - k, 0, 2, 2 + k);
    // Set 0 is full now: each miss evicts the least recent way.
    add_row(64'h10_0000, 1'b1, 1'b0, 15, 0, 2, 18);
    add_row(64'h0, 1'b1, 1'b0, 14, 0, 2, 19);
    add_row(64'h2_0000, 1'b1, 1'b1, 13, 0, 3, 19);
    add_row(64'h8000_0000_0000_0000, 1'b1, 1'b0, 12, 0, 3, 20);
    add_row(64'hFFC0, 1'b1, 1'b0, 14, 1023, 3, 21);
    add_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 0, 0, 0, 0);
    add_row(64'h5555_5555_5555_5555, 1'b0, 1'b0, 0, 0, 0, 0);

    foreach (access_table[i])
      offer_access(access_table[i].addr, access_table[i].typed, access_table[i].want);

    // Small pools keep sets crowded so hits, evictions and same-set
    // back-to-back lookups are frequent.
    foreach (set_pool[i]) set_pool[i] = SET_BITS'($urandom);
    set_pool[0] = '0;
    set_pool[1] = '1;
    foreach (tag_pool[i]) tag_pool[i] = {16'($urandom), 32'($urandom)};
    tag_pool[0] = '1;
    tag_pool[1] = '0;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 250) begin
        hold_off_req = 1'b1;
        send_burst   = 1'b1;
      end
      if (n == 500) begin
        in_valid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge clk);
      end
      pick      = $urandom_range(0, 99);
      set_index = set_pool[$urandom_range(0, 7)];
      tag       = tag_pool[$urandom_range(0, 19)];
      offset    = OFFSET_BITS'($urandom);
      if (pick >= 80) tag = {16'($urandom), 32'($urandom)};
      addr = {tag, set_index, offset};
      if (pick >= 90) addr = {$urandom, $urandom};
      offer_access(addr, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
